@@ hw/rtl/char_cell_diff_renderer_defines.svh @@
// Assertion macros shared by the character cell difference renderer.
// Included by the top level; depends on nothing else.
`ifndef CHAR_CELL_DIFF_RENDERER_DEFINES_SVH
`define CHAR_CELL_DIFF_RENDERER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CCDR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ccdr: implication check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define CCDR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ccdr: next-cycle check failed");

`endif

@@ hw/rtl/ccdr_pkg.sv @@
// Shared types, constants and the resolution table of the character cell renderer.
// Used by every module of the block; depends on nothing.
package ccdr_pkg;

    // Screen geometry. The line length is a power of two, so the cell column and
    // text row are a mask and a shift of the screen address.
    localparam int CELLS_PER_LINE = 64;
    localparam int SCREEN_CELLS   = 1024;
    localparam int GLYPH_BYTES    = 2048;
    localparam int LINE_SHIFT     = $clog2(CELLS_PER_LINE);
    localparam int SA_W           = $clog2(SCREEN_CELLS);
    localparam int GA_W           = $clog2(GLYPH_BYTES);
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [9:0] DISP_WIDTH_RESET  = 10'd320;
    localparam logic [9:0] DISP_HEIGHT_RESET = 10'd240;

    // Item kinds.
    localparam logic KIND_SCREEN = 1'b0;
    localparam logic KIND_GLYPH  = 1'b1;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_RES_SEL     = 2'd0,
        CFG_COL_OFFSET  = 2'd1,
        CFG_DISP_WIDTH  = 2'd2,
        CFG_DISP_HEIGHT = 2'd3
    } t_cfg_index;

    // Input beat.
    typedef struct packed {
        logic       kind;
        logic [9:0] screen_address;
        logic [7:0] char_code;
        logic [10:0] glyph_address;
        logic [7:0] glyph_byte;
    } t_in_item;

    // Output beat: one changed glyph row.
    typedef struct packed {
        logic [9:0] pixel_x;
        logic [9:0] pixel_y;
        logic [7:0] change_mask;
        logic [7:0] new_pattern;
        logic       last;
    } t_out_item;

    // Cell shape: width 8 or 7, height 8 or 7, and row doubling.
    typedef struct packed {
        logic wide8;
        logic tall8;
        logic dbl;
    } t_mode;

    // Classified command passed from the front end to the back end.
    typedef struct packed {
        logic             kind;
        logic [SA_W-1:0]  sa;
        logic             in_range;
        logic [7:0]       code;
        logic [GA_W-1:0]  glyph_address;
        logic [7:0]       glyph_byte;
        logic             visible;
        logic [9:0]       x;
        logic [9:0]       y;
        t_mode            mode;
    } t_cmd;

    // Back-end status seen by the front end and the top level.
    typedef struct packed {
        logic clearing;
        logic idle;
    } t_back_status;

    typedef enum logic [2:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_OLD,
        BS_ROWS,
        BS_FLUSH
    } t_back_state;

    // Resolution table; unused selections fall back to the first entry.
    function automatic t_mode mode_lookup(input logic [2:0] sel);
        t_mode m;
        case (sel)
            3'd0: m = '{wide8: 1'b1, tall8: 1'b1, dbl: 1'b0};
            3'd1: m = '{wide8: 1'b1, tall8: 1'b1, dbl: 1'b1};
            3'd2: m = '{wide8: 1'b0, tall8: 1'b1, dbl: 1'b0};
            3'd3: m = '{wide8: 1'b0, tall8: 1'b0, dbl: 1'b0};
            3'd4: m = '{wide8: 1'b0, tall8: 1'b0, dbl: 1'b1};
            default: m = '{wide8: 1'b1, tall8: 1'b1, dbl: 1'b0};
        endcase
        return m;
    endfunction

endpackage

@@ hw/rtl/ccdr_front.sv @@
// Front end: accepts input beats and classifies them into commands.
// Depends on ccdr_pkg for the command type and the resolution table.
module ccdr_front (
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  ccdr_pkg::t_in_item    i_in_item,
    input  logic [2:0]            i_res_sel,
    input  logic signed [4:0]     i_col_offset,
    input  logic [9:0]            i_disp_width,
    input  logic [9:0]            i_disp_height,
    input  ccdr_pkg::t_back_status i_status,
    output logic                  o_push_valid,
    input  logic                  i_push_ready,
    output ccdr_pkg::t_cmd        o_push_cmd
);
    localparam int COL_W = ccdr_pkg::LINE_SHIFT + 2;
    localparam int ROW_W = 10 - ccdr_pkg::LINE_SHIFT;

    ccdr_pkg::t_mode                  mode;
    logic [ccdr_pkg::LINE_SHIFT-1:0]  line_col;
    logic [ROW_W-1:0]                 text_row;
    logic signed [COL_W-1:0]          col;
    logic [3:0]                       cell_w;
    logic [3:0]                       cell_h;
    logic [4:0]                       row_step;
    logic signed [15:0]               x16;
    logic [15:0]                      y16;
    logic                             x_ok;
    logic                             y_ok;

    // Cell column and text row from the screen address.
    always_comb begin
        mode     = ccdr_pkg::mode_lookup(i_res_sel);
        line_col = i_in_item.screen_address[ccdr_pkg::LINE_SHIFT-1:0];
        text_row = i_in_item.screen_address[9:ccdr_pkg::LINE_SHIFT];
        col      = $signed({2'b00, line_col})
                 + $signed({{(COL_W-5){i_col_offset[4]}}, i_col_offset});
        cell_w   = mode.wide8 ? 4'd8 : 4'd7;
        cell_h   = mode.tall8 ? 4'd8 : 4'd7;
        row_step = mode.dbl ? {cell_h, 1'b0} : {1'b0, cell_h};
    end

    // Pixel position and the on-display test.
    always_comb begin
        x16  = $signed({{(16-COL_W){col[COL_W-1]}}, col}) * $signed({12'd0, cell_w});
        y16  = 16'(text_row) * 16'(row_step);
        x_ok = !x16[15] && (x16 < $signed({6'd0, i_disp_width}));
        y_ok = y16 < {6'd0, i_disp_height};
    end

    // Command assembly.
    always_comb begin
        o_push_cmd.kind          = i_in_item.kind;
        o_push_cmd.sa            = ccdr_pkg::SA_W'(i_in_item.screen_address);
        o_push_cmd.in_range      = 32'(i_in_item.screen_address)
                                 < 32'(ccdr_pkg::SCREEN_CELLS);
        o_push_cmd.code          = i_in_item.char_code;
        o_push_cmd.glyph_address = i_in_item.glyph_address;
        o_push_cmd.glyph_byte    = i_in_item.glyph_byte;
        o_push_cmd.visible       = x_ok && y_ok;
        o_push_cmd.x             = x16[9:0];
        o_push_cmd.y             = y16[9:0];
        o_push_cmd.mode          = mode;
    end

    // No beats are taken while the screen store is being cleared.
    assign o_in_ready   = i_push_ready && !i_status.clearing;
    assign o_push_valid = i_in_valid && !i_status.clearing;

endmodule

@@ hw/rtl/ccdr_queue.sv @@
// Short command queue that decouples the front end from the back end.
// Depends on ccdr_pkg for the command type and the depth.
module ccdr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  ccdr_pkg::t_cmd i_push_cmd,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output ccdr_pkg::t_cmd o_pop_cmd
);
    localparam int PTR_W = $clog2(ccdr_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(ccdr_pkg::QUEUE_DEPTH + 1);

    ccdr_pkg::t_cmd   r_entries [ccdr_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push;
    logic             pop;

    assign o_push_ready = r_count != CNT_W'(ccdr_pkg::QUEUE_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_cmd    = r_entries[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Pointer and fill count update; pointers wrap at the depth.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(ccdr_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(ccdr_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({push, pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_entries[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

@@ hw/rtl/ccdr_back.sv @@
// Back end: owns the screen and glyph stores, compares glyph rows and emits
// changed-row beats. Depends on ccdr_pkg for types, constants and states.
module ccdr_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_pop_valid,
    output logic                   o_pop_ready,
    input  ccdr_pkg::t_cmd         i_pop_cmd,
    input  logic [9:0]             i_disp_height,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output ccdr_pkg::t_out_item    o_out_item,
    output ccdr_pkg::t_back_status o_status
);
    localparam int SA_W = ccdr_pkg::SA_W;
    localparam int GA_W = ccdr_pkg::GA_W;

    ccdr_pkg::t_back_state r_state, n_state;
    logic [SA_W-1:0]       r_clr_addr, n_clr_addr;
    ccdr_pkg::t_cmd        r_job, n_job;
    logic [4:0]            r_step, n_step;
    logic                  r_p_valid, n_p_valid;
    logic [3:0]            r_p_step, n_p_step;
    logic                  r_held_valid, n_held_valid;
    ccdr_pkg::t_out_item   r_held, n_held;
    logic                  r_out_valid, n_out_valid;
    ccdr_pkg::t_out_item   r_out, n_out;

    logic [7:0]            r_screen_mem [ccdr_pkg::SCREEN_CELLS];
    logic [7:0]            r_glyph_mem  [ccdr_pkg::GLYPH_BYTES];
    logic [7:0]            r_old_code;
    logic [7:0]            r_new_row;
    logic [7:0]            r_old_row;

    logic                  head_screen;
    logic                  head_draw;
    logic                  screen_we;
    logic [SA_W-1:0]       screen_waddr;
    logic [7:0]            screen_wdata;
    logic                  screen_re;
    logic                  glyph_we;
    logic [3:0]            cell_h;
    logic [4:0]            total;
    logic [2:0]            row_j;
    logic [GA_W-1:0]       new_gaddr;
    logic [GA_W-1:0]       old_gaddr;
    logic [7:0]            wmask;
    logic [7:0]            diff;
    logic [10:0]           py;
    logic                  cand_valid;
    ccdr_pkg::t_out_item   cand;
    logic                  out_free;
    logic                  stall;
    logic                  issuing;

    // Head-of-queue classification.
    assign head_screen = i_pop_valid && (i_pop_cmd.kind == ccdr_pkg::KIND_SCREEN)
                       && i_pop_cmd.in_range;
    assign head_draw   = head_screen && i_pop_cmd.visible;

    // Row walk bookkeeping: one step per pixel row of the cell.
    always_comb begin
        cell_h    = r_job.mode.tall8 ? 4'd8 : 4'd7;
        total     = r_job.mode.dbl ? {cell_h, 1'b0} : {1'b0, cell_h};
        row_j     = r_job.mode.dbl ? r_step[3:1] : r_step[2:0];
        new_gaddr = {r_job.code, row_j};
        old_gaddr = {r_old_code, row_j};
    end

    // Compare stage on the registered glyph rows.
    always_comb begin
        wmask      = r_job.mode.wide8 ? 8'hFF : 8'h7F;
        diff       = (r_new_row ^ r_old_row) & wmask;
        py         = {1'b0, r_job.y} + {7'd0, r_p_step};
        cand_valid = r_p_valid && (diff != 8'd0) && (py < {1'b0, i_disp_height});
        cand       = '{pixel_x: r_job.x, pixel_y: py[9:0], change_mask: diff,
                       new_pattern: r_new_row & wmask, last: 1'b0};
    end

    // The walk stops when a new record finds both the hold slot and the output full.
    assign out_free = !r_out_valid || i_out_ready;
    assign stall    = (r_state == ccdr_pkg::BS_ROWS) && cand_valid && r_held_valid
                    && !out_free;
    assign issuing  = (r_state == ccdr_pkg::BS_ROWS) && (r_step < total) && !stall;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ccdr_pkg::BS_CLEAR: begin
                if (r_clr_addr == SA_W'(ccdr_pkg::SCREEN_CELLS - 1)) begin
                    n_state = ccdr_pkg::BS_IDLE;
                end
            end
            ccdr_pkg::BS_IDLE: begin
                if (head_draw) begin
                    n_state = ccdr_pkg::BS_OLD;
                end
            end
            ccdr_pkg::BS_OLD: begin
                n_state = ccdr_pkg::BS_ROWS;
            end
            ccdr_pkg::BS_ROWS: begin
                if ((r_step == total) && !r_p_valid) begin
                    n_state = ccdr_pkg::BS_FLUSH;
                end
            end
            ccdr_pkg::BS_FLUSH: begin
                if (!r_held_valid || out_free) begin
                    n_state = ccdr_pkg::BS_IDLE;
                end
            end
            default: n_state = ccdr_pkg::BS_IDLE;
        endcase
    end

    // Store controls and queue pop for each state.
    always_comb begin
        o_pop_ready  = 1'b0;
        screen_we    = 1'b0;
        screen_waddr = r_clr_addr;
        screen_wdata = 8'd0;
        screen_re    = 1'b0;
        glyph_we     = 1'b0;
        case (r_state)
            ccdr_pkg::BS_CLEAR: begin
                screen_we = 1'b1;
            end
            ccdr_pkg::BS_IDLE: begin
                o_pop_ready = 1'b1;
                glyph_we    = i_pop_valid && (i_pop_cmd.kind == ccdr_pkg::KIND_GLYPH);
                screen_re   = head_draw;
                // Off-display writes only update the stored code.
                if (head_screen && !i_pop_cmd.visible) begin
                    screen_we    = 1'b1;
                    screen_waddr = i_pop_cmd.sa;
                    screen_wdata = i_pop_cmd.code;
                end
            end
            ccdr_pkg::BS_OLD: begin
                // The old code is already captured, so the cell takes its new code now.
                screen_we    = 1'b1;
                screen_waddr = r_job.sa;
                screen_wdata = r_job.code;
            end
            default: begin
                screen_we = 1'b0;
            end
        endcase
    end

    // Datapath next values: job, walk counters, hold slot and output register.
    always_comb begin
        n_clr_addr   = (r_state == ccdr_pkg::BS_CLEAR) ? r_clr_addr + 1'b1 : r_clr_addr;
        n_job        = (r_state == ccdr_pkg::BS_IDLE && i_pop_valid) ? i_pop_cmd : r_job;
        n_step       = r_step;
        if (r_state == ccdr_pkg::BS_IDLE) begin
            n_step = 5'd0;
        end else if (issuing) begin
            n_step = r_step + 5'd1;
        end
        n_p_valid    = stall ? r_p_valid : issuing;
        n_p_step     = stall ? r_p_step : r_step[3:0];
        n_held_valid = r_held_valid;
        n_held       = r_held;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out        = r_out;
        if (r_state == ccdr_pkg::BS_ROWS && cand_valid) begin
            if (!r_held_valid) begin
                n_held       = cand;
                n_held_valid = 1'b1;
            end else if (out_free) begin
                n_out        = r_held;
                n_out_valid  = 1'b1;
                n_held       = cand;
            end
        end
        // The record still held at the end of the walk is the final one.
        if (r_state == ccdr_pkg::BS_FLUSH && r_held_valid && out_free) begin
            n_out        = r_held;
            n_out.last   = 1'b1;
            n_out_valid  = 1'b1;
            n_held_valid = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ccdr_pkg::BS_CLEAR;
            r_clr_addr   <= '0;
            r_step       <= 5'd0;
            r_p_valid    <= 1'b0;
            r_held_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_step       <= n_step;
            r_p_valid    <= n_p_valid;
            r_held_valid <= n_held_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_job    <= n_job;
        r_p_step <= n_p_step;
        r_held   <= n_held;
        r_out    <= n_out;
    end

    // Screen store: one write and one registered read port.
    always_ff @(posedge i_clk) begin
        if (screen_we) begin
            r_screen_mem[screen_waddr] <= screen_wdata;
        end
        if (screen_re) begin
            r_old_code <= r_screen_mem[i_pop_cmd.sa];
        end
    end

    // Glyph store: one write and two registered read ports for new and old rows.
    always_ff @(posedge i_clk) begin
        if (glyph_we) begin
            r_glyph_mem[i_pop_cmd.glyph_address] <= i_pop_cmd.glyph_byte;
        end
        if (issuing) begin
            r_new_row <= r_glyph_mem[new_gaddr];
            r_old_row <= r_glyph_mem[old_gaddr];
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_item        = r_out;
    assign o_status.clearing = r_state == ccdr_pkg::BS_CLEAR;
    assign o_status.idle     = r_state == ccdr_pkg::BS_IDLE;

endmodule

@@ hw/rtl/char_cell_diff_renderer.sv @@
// Character cell renderer: the back end takes glyph loads and off-display screen writes
// in its idle state. A drawn screen write reads the old code, writes the new one and
// walks the pixel rows of the cell (twice as many when doubled), reading and comparing
// one glyph row per cycle while the output does not stall. Commands reach the back end
// through the queue; a record passes the glyph read, the compare and the hold slot first.
// Reset clears the screen store, during which no input beat is taken.
`include "char_cell_diff_renderer_defines.svh"

module char_cell_diff_renderer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ccdr_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ccdr_pkg::t_out_item o_out_item,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [9:0]          i_cfg_data
);
    logic [2:0]             r_res_sel;
    logic signed [4:0]      r_col_offset;
    logic [9:0]             r_disp_width;
    logic [9:0]             r_disp_height;

    logic                   q_push_valid;
    logic                   q_push_ready;
    ccdr_pkg::t_cmd         q_push_cmd;
    logic                   q_pop_valid;
    logic                   q_pop_ready;
    ccdr_pkg::t_cmd         q_pop_cmd;
    ccdr_pkg::t_back_status back_status;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_sel     <= 3'd0;
            r_col_offset  <= 5'sd0;
            r_disp_width  <= ccdr_pkg::DISP_WIDTH_RESET;
            r_disp_height <= ccdr_pkg::DISP_HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (ccdr_pkg::t_cfg_index'(i_cfg_index))
                ccdr_pkg::CFG_RES_SEL:     r_res_sel     <= i_cfg_data[2:0];
                ccdr_pkg::CFG_COL_OFFSET:  r_col_offset  <= $signed(i_cfg_data[4:0]);
                ccdr_pkg::CFG_DISP_WIDTH:  r_disp_width  <= i_cfg_data;
                ccdr_pkg::CFG_DISP_HEIGHT: r_disp_height <= i_cfg_data;
                default:                   r_res_sel     <= r_res_sel;
            endcase
        end
    end

    // Front end classifies each beat.
    ccdr_front u_front (
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_item     (i_in_item),
        .i_res_sel     (r_res_sel),
        .i_col_offset  (r_col_offset),
        .i_disp_width  (r_disp_width),
        .i_disp_height (r_disp_height),
        .i_status      (back_status),
        .o_push_valid  (q_push_valid),
        .i_push_ready  (q_push_ready),
        .o_push_cmd    (q_push_cmd)
    );

    // Command queue between the two halves.
    ccdr_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (q_push_valid),
        .o_push_ready (q_push_ready),
        .i_push_cmd   (q_push_cmd),
        .o_pop_valid  (q_pop_valid),
        .i_pop_ready  (q_pop_ready),
        .o_pop_cmd    (q_pop_cmd)
    );

    // Back end carries out commands against the stores.
    ccdr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pop_valid   (q_pop_valid),
        .o_pop_ready   (q_pop_ready),
        .i_pop_cmd     (q_pop_cmd),
        .i_disp_height (r_disp_height),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_item    (o_out_item),
        .o_status      (back_status)
    );

    // Nothing can reach the queue or the output while the screen store is cleared.
    `CCDR_ASSERT_IMPLIES(a_clear_queue_empty, i_clk, i_rst_n, back_status.clearing, !q_pop_valid)
    `CCDR_ASSERT_IMPLIES(a_clear_no_output, i_clk, i_rst_n, back_status.clearing, !o_out_valid)
    // Every record lies on a display row.
    `CCDR_ASSERT_IMPLIES(a_row_on_display, i_clk, i_rst_n, o_out_valid, o_out_item.pixel_y < r_disp_height)
    // An accepted beat is waiting in the queue on the next cycle.
    `CCDR_ASSERT_NEXT(a_accept_queued, i_clk, i_rst_n, i_in_valid && o_in_ready, q_pop_valid)

endmodule
